>>> sv/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared sizes and operation codes of the smallest free ID allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

  // Largest ID that the allocator hands out.
  localparam int VALUE_LIMIT = 1024;

  // Heap index, heap fill count and ID widths (an ID runs up to VALUE_LIMIT + 1).
  localparam int IDX_W   = $clog2(VALUE_LIMIT);
  localparam int CNT_W   = $clog2(VALUE_LIMIT + 1);
  localparam int ID_W    = $clog2(VALUE_LIMIT + 2);
  localparam int CH_W    = IDX_W + 2;
  localparam int TDATA_W = ((ID_W + 7) / 8) * 8;

  localparam logic OP_POP = 1'b0;
  localparam logic OP_ADD = 1'b1;

endpackage

`default_nettype wire

>>> sv/smallest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// smallest_free_id_allocator
// Hands out the smallest free ID from a min-heap of returned IDs in RAM and
// a fresh-ID counter.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries an opcode in in_tuser and an ID in
//   in_tdata. A pop yields one result on the out_ channel: the smallest free
//   ID, or ID 0 with the exhausted flag in out_tuser when none is left. An
//   add-back yields no result.
//   The pop result is registered. The request is taken in ST_IDLE while the
//   heap top is read; ST_POP_TOP then loads the output register, waiting
//   there while it is still full. Afterwards the heap is repaired by a
//   sift-down that spends per heap level two child reads, a compare and a
//   write back. An add-back checks the membership bitmap, then sifts up
//   with a parent read, a compare and a write back per level.
//   The single read port of the heap RAM sets this order; one request is
//   worked on at a time and in_tready is high only between requests.
//   Reset empties the heap and sets the fresh counter to 1 at once. The
//   membership bitmap needs no clearing pass: each ID's bit is written to
//   zero when that ID is first handed out, and only such IDs are looked up.
//   A stalled receiver holds the finished result in the output register; a
//   new request is still taken, but a following pop waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_free_id_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [sfa_pkg::TDATA_W-1:0] in_tdata,  // id_value, zero pad
  input  wire logic                        in_tuser,  // opcode
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [sfa_pkg::TDATA_W-1:0] out_tdata, // popped_id, zero pad
  output logic                             out_tuser  // exhausted
);

  import sfa_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_POP_TOP  = 10'b00_0000_0010,
    ST_POP_LAST = 10'b00_0000_0100,
    ST_SD_CHK   = 10'b00_0000_1000,
    ST_SD_L     = 10'b00_0001_0000,
    ST_SD_R     = 10'b00_0010_0000,
    ST_SD_DEC   = 10'b00_0100_0000,
    ST_ADD_CHK  = 10'b00_1000_0000,
    ST_SU_CHK   = 10'b01_0000_0000,
    ST_SU_CMP   = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ID_W-1:0]   fresh_r, fresh_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [ID_W-1:0]   best_val_r, best_val_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_exh_r, out_exh_nxt;

  logic              heap_we, heap_re;
  logic [IDX_W-1:0]  heap_waddr, heap_raddr;
  logic [ID_W-1:0]   heap_wdata, heap_rdata;
  logic              bm_we, bm_re;
  logic [IDX_W-1:0]  bm_waddr, bm_raddr;
  logic              bm_wdata, bm_rdata;

  logic              in_fire, out_free, take_heap, add_ok;
  logic [ID_W-1:0]   in_id;
  logic [CH_W-1:0]   left_idx, right_idx, cnt_ext;
  logic [IDX_W-1:0]  up_idx;

  sfa_ram #(.WIDTH(ID_W), .DEPTH(VALUE_LIMIT)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .re    (heap_re),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  sfa_ram #(.WIDTH(1), .DEPTH(VALUE_LIMIT)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_id     = in_tdata[ID_W-1:0];
  assign out_free  = !out_valid_r || out_tready;

  assign left_idx  = {1'b0, pos_r, 1'b1};
  assign right_idx = left_idx + CH_W'(1);
  assign cnt_ext   = CH_W'(cnt_r);
  assign up_idx    = IDX_W'((pos_r - IDX_W'(1)) >> 1);

  // The heap top is usable only while it lies below the fresh counter.
  assign take_heap = (cnt_r != '0) && (heap_rdata < fresh_r);
  assign add_ok    = (id_r != '0) && (id_r < fresh_r) && !bm_rdata
                  && (cnt_r < CNT_W'(VALUE_LIMIT));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fresh_nxt     = fresh_r;
    id_nxt        = id_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    best_val_nxt  = best_val_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_exh_nxt   = out_exh_r;
    heap_we       = 1'b0;
    heap_waddr    = pos_r;
    heap_wdata    = cur_r;
    heap_re       = 1'b0;
    heap_raddr    = '0;
    bm_we         = 1'b0;
    bm_waddr      = IDX_W'(heap_rdata - ID_W'(1));
    bm_wdata      = 1'b0;
    bm_re         = 1'b0;
    bm_raddr      = IDX_W'(in_id - ID_W'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          id_nxt = in_id;
          if (in_tuser == OP_POP) begin
            heap_re   = 1'b1;
            state_nxt = ST_POP_TOP;
          end else begin
            bm_re     = 1'b1;
            state_nxt = ST_ADD_CHK;
          end
        end
      end
      ST_POP_TOP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (take_heap) begin
            out_id_nxt  = heap_rdata;
            out_exh_nxt = 1'b0;
            bm_we       = 1'b1;
            cnt_nxt     = cnt_r - CNT_W'(1);
            heap_re     = 1'b1;
            heap_raddr  = IDX_W'(cnt_r - CNT_W'(1));
            state_nxt   = ST_POP_LAST;
          end else if (fresh_r <= ID_W'(VALUE_LIMIT)) begin
            // First hand-out of this ID also initializes its bitmap entry.
            out_id_nxt  = fresh_r;
            out_exh_nxt = 1'b0;
            bm_we       = 1'b1;
            bm_waddr    = IDX_W'(fresh_r - ID_W'(1));
            fresh_nxt   = fresh_r + ID_W'(1);
            state_nxt   = ST_IDLE;
          end else begin
            out_id_nxt  = '0;
            out_exh_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_POP_LAST: begin
        cur_nxt   = heap_rdata;
        pos_nxt   = '0;
        state_nxt = (cnt_r == '0) ? ST_IDLE : ST_SD_CHK;
      end
      ST_SD_CHK: begin
        if (left_idx < cnt_ext) begin
          heap_re    = 1'b1;
          heap_raddr = IDX_W'(left_idx);
          state_nxt  = ST_SD_L;
        end else begin
          heap_we   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SD_L: begin
        if (heap_rdata < cur_r) begin
          best_val_nxt = heap_rdata;
          best_idx_nxt = IDX_W'(left_idx);
        end else begin
          best_val_nxt = cur_r;
          best_idx_nxt = pos_r;
        end
        if (right_idx < cnt_ext) begin
          heap_re    = 1'b1;
          heap_raddr = IDX_W'(right_idx);
          state_nxt  = ST_SD_R;
        end else begin
          state_nxt = ST_SD_DEC;
        end
      end
      ST_SD_R: begin
        if (heap_rdata < best_val_r) begin
          best_val_nxt = heap_rdata;
          best_idx_nxt = IDX_W'(right_idx);
        end
        state_nxt = ST_SD_DEC;
      end
      ST_SD_DEC: begin
        heap_we = 1'b1;
        if (best_idx_r == pos_r) begin
          state_nxt = ST_IDLE;
        end else begin
          // The smaller child moves up; the moving value goes one level down.
          heap_wdata = best_val_r;
          pos_nxt    = best_idx_r;
          state_nxt  = ST_SD_CHK;
        end
      end
      ST_ADD_CHK: begin
        if (add_ok) begin
          bm_we     = 1'b1;
          bm_waddr  = IDX_W'(id_r - ID_W'(1));
          bm_wdata  = 1'b1;
          pos_nxt   = IDX_W'(cnt_r);
          cur_nxt   = id_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_SU_CHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SU_CHK: begin
        if (pos_r == '0) begin
          heap_we   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = up_idx;
          state_nxt  = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        heap_we = 1'b1;
        if (heap_rdata <= cur_r) begin
          state_nxt = ST_IDLE;
        end else begin
          heap_wdata = heap_rdata;
          pos_nxt    = up_idx;
          state_nxt  = ST_SU_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fresh_r     <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r       <= id_nxt;
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    out_id_r   <= out_id_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_id_r);
  assign out_tuser  = out_exh_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_LIMIT))
    else $error("heap count above limit");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r != '0 && fresh_r <= ID_W'(VALUE_LIMIT + 1))
    else $error("fresh counter out of range");

  a_sift_up_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SU_CHK |-> cnt_r != '0 && CNT_W'(pos_r) < cnt_r)
    else $error("sift-up position outside heap");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exh_r |-> out_id_r == '0 && fresh_r > ID_W'(VALUE_LIMIT))
    else $error("exhausted result while IDs remain");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(state_r) == ST_POP_TOP)
    else $error("result raised outside pop decision");

endmodule

`default_nettype wire

>>> sv/sfa_ram.sv
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
